// ----- src/float_to_pcm_sample_converter_defines.svh -----
// assertion macros for the float to pcm sample converter
`ifndef FLOAT_TO_PCM_SAMPLE_CONVERTER_DEFINES_SVH
`define FLOAT_TO_PCM_SAMPLE_CONVERTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define F2P_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("f2p check failed");

// next-cycle implication, checked out of reset
`define F2P_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("f2p check failed");

`endif

// ----- src/f2p_pkg.sv -----
// shared types, constants and helpers of the float to pcm converter
package f2p_pkg;

    typedef enum logic [1:0] {
        FMT_S16 = 2'd0,
        FMT_U16 = 2'd1,
        FMT_S8  = 2'd2,
        FMT_U8  = 2'd3
    } fmt_t;

    localparam logic [14:0] SCALE16 = 15'd32767;
    localparam logic [14:0] SCALE8  = 15'd127;
    // magnitude bits of 1.0f
    localparam logic [30:0] ONE_MAG = 31'h3F80_0000;

    localparam logic [15:0] TOP_S16 = 16'h7FFF;
    localparam logic [15:0] BOT_S16 = 16'h8000;
    localparam logic [15:0] TOP_U16 = 16'hFFFF;
    localparam logic [15:0] TOP_S8  = 16'h007F;
    localparam logic [15:0] BOT_S8  = 16'h0080;
    localparam logic [15:0] TOP_U8  = 16'h00FF;

    function automatic logic [14:0] scale_of(fmt_t f);
        return f[1] ? SCALE8 : SCALE16;
    endfunction

    // after decode and alignment of |s| to a 2^-55 grid
    typedef struct packed {
        fmt_t        fmt;
        logic        sign;
        logic        nan;
        logic        clip;
        logic [7:0]  expo;
        logic [23:0] man;
        logic [54:0] mag;
        logic        sticky;
    } algn_t;

    // after the double-precision sum and the signed product
    typedef struct packed {
        fmt_t        fmt;
        logic        sign;
        logic        nan;
        logic        clip;
        logic [7:0]  expo;
        logic [38:0] sprod;
        logic [53:0] tq;
    } sum_t;

    // after the unsigned product and the signed rounding
    typedef struct packed {
        fmt_t        fmt;
        logic        sign;
        logic        nan;
        logic        clip;
        logic [15:0] smag;
        logic [68:0] uprod;
    } mul_t;

    typedef struct packed {
        logic [15:0] code;
        logic        clip;
        logic        nan;
    } res_t;

endpackage

// ----- src/float_to_pcm_sample_converter.sv -----
// Converts single-precision audio samples to 16- or 8-bit signed or unsigned
// PCM codes, with clip and NaN flags. One item is accepted every clock while
// the output does not stall, through a four-stage pipeline (align, add and
// signed multiply, unsigned multiply and signed rounding, final rounding and
// code select); an output stall holds every full stage, empty ones still fill.
// Write sample_format only while no item is in flight.
`include "float_to_pcm_sample_converter_defines.svh"
module float_to_pcm_sample_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,     // sample_format
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // float_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // pcm_code
    output logic [1:0]  m_tuser        // invalid, clipped
);
    import f2p_pkg::*;

    fmt_t   fmt_reg;
    logic   a_valid;
    logic   a_ready;
    algn_t  a_data;
    logic   b_valid;
    logic   b_ready;
    sum_t   b_data;
    logic   c_valid;
    logic   c_ready;
    mul_t   c_data;
    res_t   res;

    // format register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_S16;
        end else if (cfg_we) begin
            fmt_reg <= fmt_t'(cfg_wdata);
        end
    end

    f2p_align u_align (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_bits   (s_tdata),
        .in_fmt    (fmt_reg),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_data  (a_data)
    );

    f2p_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_data   (a_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    f2p_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_data   (b_data),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    f2p_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = res.code;
    assign m_tuser = {res.nan, res.clip};

    // a nan gives a zero code and no clip
    `F2P_ASSERT_NOW(a_nan_zero, m_tvalid && m_tuser[1], m_tdata == 16'd0 && !m_tuser[0])
    // 8-bit formats leave the high byte clear
    `F2P_ASSERT_NOW(a_byte_clear, m_tvalid && fmt_reg[1], m_tdata[15:8] == 8'd0)
    // signed 16 clipping lands on one of the two end codes
    `F2P_ASSERT_NOW(a_s16_clip, m_tvalid && m_tuser[0] && fmt_reg == FMT_S16,
        m_tdata == TOP_S16 || m_tdata == BOT_S16)

endmodule

// ----- src/f2p_align.sv -----
// stage one: decode the sample and align its magnitude with sticky bit
module f2p_align (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [31:0]      in_bits,
    input  f2p_pkg::fmt_t    in_fmt,
    output logic             out_valid,
    input  logic             out_ready,
    output f2p_pkg::algn_t   out_data
);
    import f2p_pkg::*;

    logic        valid_reg;
    algn_t       data_reg;
    algn_t       data_next;
    logic [7:0]  expo;
    logic [7:0]  eff_exp;
    logic [7:0]  sh;
    logic [23:0] man;
    logic [78:0] ext;
    logic [78:0] shifted;

    // decode and shift m * 2^(e-150) onto the 2^-55 grid
    always_comb begin
        expo    = in_bits[30:23];
        eff_exp = (expo == 8'd0) ? 8'd1 : expo;
        man     = {expo != 8'd0, in_bits[22:0]};
        ext     = {man, 55'b0};
        sh      = 8'd150 - eff_exp;
        shifted = ext >> sh;
        data_next.fmt    = in_fmt;
        data_next.sign   = in_bits[31];
        data_next.nan    = (&expo) && (|in_bits[22:0]);
        data_next.clip   = !data_next.nan && (in_bits[30:0] >= ONE_MAG);
        data_next.expo   = expo;
        data_next.man    = man;
        data_next.mag    = shifted[54:0];
        data_next.sticky = (shifted << sh) != ext;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- src/f2p_sum.sv -----
// stage two: 1.0 + s rounded to double, and the single-precision product
module f2p_sum (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  f2p_pkg::algn_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output f2p_pkg::sum_t    out_data
);
    import f2p_pkg::*;

    logic        valid_reg;
    sum_t        data_reg;
    sum_t        data_next;
    logic [55:0] tv;
    logic [52:0] keep;
    logic [53:0] keep_r;
    logic        guard;
    logic        st;
    logic        up;

    // add or subtract on the 2^-55 grid, then round to nearest even
    always_comb begin
        if (in_data.sign) begin
            tv = {1'b1, 55'b0} - {1'b0, in_data.mag} - {55'b0, in_data.sticky};
        end else begin
            tv = {1'b1, 55'b0} + {1'b0, in_data.mag};
        end
        if (tv[55]) begin
            keep  = tv[55:3];
            guard = tv[2];
            st    = tv[1] | tv[0] | in_data.sticky;
        end else begin
            keep  = tv[54:2];
            guard = tv[1];
            st    = tv[0] | in_data.sticky;
        end
        up     = guard && (st || keep[0]);
        // a tiny negative sample can round 1.0 + s up to exactly 1.0
        keep_r = {1'b0, keep} + {53'b0, up};
        data_next.fmt   = in_data.fmt;
        data_next.sign  = in_data.sign;
        data_next.nan   = in_data.nan;
        data_next.clip  = in_data.clip;
        data_next.expo  = in_data.expo;
        data_next.sprod = 39'(in_data.man) * 39'(scale_of(in_data.fmt));
        data_next.tq    = tv[55] ? {keep_r[52:0], 1'b0} : keep_r;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- src/f2p_mul.sv -----
// stage three: double product by the scale, signed product rounding
module f2p_mul (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  f2p_pkg::sum_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output f2p_pkg::mul_t    out_data
);
    import f2p_pkg::*;

    logic        valid_reg;
    mul_t        data_reg;
    mul_t        data_next;
    logic [3:0]  r;
    logic [38:0] q;
    logic        guard;
    logic        st;
    logic        up;
    logic [24:0] rnd;
    logic [8:0]  sh;
    logic [24:0] ival;

    // round the exact product to 24 bits, then truncate to integer
    always_comb begin
        if (in_data.fmt[1]) begin
            r = in_data.sprod[30] ? 4'd7 : 4'd6;
        end else begin
            r = in_data.sprod[38] ? 4'd15 : 4'd14;
        end
        q     = in_data.sprod >> r;
        guard = in_data.sprod[r - 4'd1];
        st    = (in_data.sprod & ((39'd1 << (r - 4'd1)) - 39'd1)) != 39'd0;
        up    = guard && (st || q[0]);
        rnd   = {1'b0, q[23:0]} + {24'b0, up};
        sh    = 9'd150 - {1'b0, in_data.expo} - {5'b0, r};
        ival  = rnd >> sh;
        data_next.fmt   = in_data.fmt;
        data_next.sign  = in_data.sign;
        data_next.nan   = in_data.nan;
        data_next.clip  = in_data.clip;
        data_next.smag  = (in_data.expo == 8'd0 || sh >= 9'd25) ? 16'd0 : ival[15:0];
        // scale is 2^7 - 1 or 2^15 - 1: shift and subtract
        data_next.uprod = in_data.fmt[1]
            ? (69'({in_data.tq, 7'b0}) - 69'(in_data.tq))
            : ({in_data.tq, 15'b0} - 69'(in_data.tq));
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- src/f2p_out.sv -----
// stage four: round the double product, pick the code, output register
module f2p_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  f2p_pkg::mul_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output f2p_pkg::res_t    out_data
);
    import f2p_pkg::*;

    logic        valid_reg;
    res_t        data_reg;
    res_t        data_next;
    logic [4:0]  d;
    logic        hit;
    logic [68:0] q;
    logic        guard;
    logic        st;
    logic        up;
    logic [53:0] rnd;
    logic [53:0] ival;
    logic [15:0] umag;
    logic [15:0] sval;

    // leading one among the integer-range bits of the product
    always_comb begin
        d   = 5'd1;
        hit = 1'b0;
        for (int i = 0; i < 16; i++) begin
            if (in_data.uprod[53 + i]) begin
                d   = 5'(i + 1);
                hit = 1'b1;
            end
        end
    end

    // round to 53 bits and truncate, then select the code
    always_comb begin
        q     = in_data.uprod >> d;
        guard = in_data.uprod[d - 5'd1];
        st    = (in_data.uprod & ((69'd1 << (d - 5'd1)) - 69'd1)) != 69'd0;
        up    = guard && (st || q[0]);
        rnd   = q[53:0] + {53'b0, up};
        ival  = rnd >> (6'd53 - {1'b0, d});
        umag  = hit ? ival[15:0] : 16'd0;
        sval  = in_data.sign ? (~in_data.smag + 16'd1) : in_data.smag;
        data_next.clip = in_data.clip;
        data_next.nan  = in_data.nan;
        if (in_data.nan) begin
            data_next.code = 16'd0;
        end else if (in_data.clip) begin
            case (in_data.fmt)
                FMT_S16: data_next.code = in_data.sign ? BOT_S16 : TOP_S16;
                FMT_U16: data_next.code = in_data.sign ? 16'd0 : TOP_U16;
                FMT_S8:  data_next.code = in_data.sign ? BOT_S8 : TOP_S8;
                default: data_next.code = in_data.sign ? 16'd0 : TOP_U8;
            endcase
        end else begin
            case (in_data.fmt)
                FMT_S16: data_next.code = sval;
                FMT_U16: data_next.code = umag;
                FMT_S8:  data_next.code = {8'b0, sval[7:0]};
                default: data_next.code = {8'b0, umag[7:0]};
            endcase
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
